// ===== design/adsr_pkg.sv =====
// ----------------------------------------------------------------------------
// adsr_pkg
// Shared types and constants of the ADSR envelope generator: request and
// result payloads, register indexes, stage codes.
// ----------------------------------------------------------------------------
package adsr_pkg;

	localparam int unsigned TIN_W     = 32;
	localparam int unsigned GATE_W    = 16;
	localparam int unsigned LEVEL_W   = 16;
	localparam int unsigned STAGE_W   = 3;
	localparam int unsigned DUR_W     = 24;
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned CFG_DAT_W = 24;

	localparam logic [CFG_IDX_W-1:0] CFG_ATTACK  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DECAY   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SUSTAIN = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_RELEASE = 2'd3;

	localparam logic [STAGE_W-1:0] STG_NONE    = 3'd0;
	localparam logic [STAGE_W-1:0] STG_ATTACK  = 3'd1;
	localparam logic [STAGE_W-1:0] STG_DECAY   = 3'd2;
	localparam logic [STAGE_W-1:0] STG_SUSTAIN = 3'd3;
	localparam logic [STAGE_W-1:0] STG_RELEASE = 3'd4;

	typedef struct packed {
		logic [TIN_W-1:0]  time_now;
		logic [GATE_W-1:0] gate_level;
	} adsr_in_t;

	typedef struct packed {
		logic [LEVEL_W-1:0] level;
		logic [STAGE_W-1:0] stage;
	} adsr_out_t;

endpackage

// ===== design/adsr_envelope_generator_core.sv =====
// ----------------------------------------------------------------------------
// adsr_envelope_generator_core
// Linear ADSR envelope with gate hysteresis; one shared multiplier and a
// serial divider run under a small sequencer.
//
//   channel  | handshake                 | payload
//   sample   | sample_valid/sample_stall | adsr_in_t  (time_now, gate_level)
//   result   | result_valid/result_stall | adsr_out_t (level, stage)
//   cfg      | cfg_valid/cfg_ready       | cfg_index, cfg_data
//
// none ends after stage selection; sustain makes one pass through the
// multiplier; attack and release add the divider (QW = max(16, FRAC_BITS+1)
// quotient bits, one per cycle, 17 by default); decay adds a second multiply.
// sample_stall is high from acceptance until the result is loaded.
// a finished result waits in the output register; a new request is taken
// meanwhile, and a result stalls in its last step only while the previous
// one is still held. reset clears config registers, gate state and control.
// ----------------------------------------------------------------------------
module adsr_envelope_generator_core #(
	parameter int unsigned TIME_WIDTH = 32,
	parameter int unsigned FRAC_BITS  = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           sample_valid,
	output logic                           sample_stall,
	input  adsr_pkg::adsr_in_t             sample,
	output logic                           result_valid,
	input  logic                           result_stall,
	output adsr_pkg::adsr_out_t            result,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [adsr_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [adsr_pkg::CFG_DAT_W-1:0] cfg_data
);
	import adsr_pkg::*;

	localparam int unsigned TW    = TIME_WIDTH;
	localparam int unsigned FB    = FRAC_BITS;
	localparam int unsigned MA    = (FB + 1 > GATE_W) ? FB + 1 : GATE_W;
	localparam int unsigned MB    = (FB + 1 > DUR_W) ? FB + 1 : DUR_W;
	localparam int unsigned PW    = MA + MB;
	localparam int unsigned LW    = PW - FB;
	localparam int unsigned HW    = (FB + 1 > 20) ? FB + 1 : 20;
	localparam int unsigned CW    = ((TW > DUR_W + 1) ? TW : DUR_W + 1) + 1;
	localparam int unsigned XW    = 26;
	localparam int unsigned ONE_I = 1 << FB;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SEL,
		S_MUL,
		S_POST,
		S_DIV,
		S_DONE
	} state_t;

	state_t state_q;

	logic [DUR_W-1:0]   attack_q;
	logic [DUR_W-1:0]   decay_q;
	logic [LEVEL_W-1:0] sustain_q;
	logic [DUR_W-1:0]   release_q;

	logic [GATE_W-1:0]  last_gate_q;
	logic [TW-1:0]      up_tick_q;
	logic [TW-1:0]      down_tick_q;

	logic [TW-1:0]      t_q;
	logic [GATE_W-1:0]  g_q;
	logic [STAGE_W-1:0] stage_q;
	logic               second_q;
	logic [MA-1:0]      op_a_q;
	logic [MB-1:0]      op_b_q;
	logic [PW-1:0]      prod_q;
	logic [DUR_W-1:0]   divisor_q;
	logic [LW-1:0]      lvl_q;
	logic               result_valid_q;
	adsr_out_t          result_q;

	logic               accept;
	logic [TW+TIN_W-1:0] t_ext;
	logic [TW-1:0]      t_in;
	logic [HW-1:0]      g10;
	logic [HW-1:0]      last5;
	logic               rise;
	logic               fall;
	logic [FB-1:0]      s_eff;
	logic [XW-1:0]      sus_x;
	logic [TW-1:0]      eu_t;
	logic [TW-1:0]      ed_t;
	logic [CW-1:0]      eu_x;
	logic [CW-1:0]      ed_x;
	logic [CW-1:0]      a_x;
	logic [CW-1:0]      ad_x;
	logic [CW-1:0]      r_x;
	logic [CW-1:0]      t_x;
	logic               direct_post;
	logic               div_start;
	logic               div_done;
	logic [MA-1:0]      div_quo;
	logic [MB:0]        f_w;
	logic [LW-1:0]      lvl_sat;
	logic               out_free;

	assign accept       = sample_valid && !sample_stall;
	assign sample_stall = (state_q != S_IDLE);
	assign cfg_ready    = 1'b1;
	assign result_valid = result_valid_q;
	assign result       = result_q;
	assign out_free     = !result_valid_q || !result_stall;

	always_comb begin
		t_ext = {{TW{1'b0}}, sample.time_now};
		t_in  = t_ext[TW-1:0];
		g10   = (HW'(sample.gate_level) << 3) + (HW'(sample.gate_level) << 1);
		last5 = (HW'(last_gate_q) << 2) + HW'(last_gate_q);
		rise  = (g10 > HW'(ONE_I)) && (last5 <= HW'(ONE_I));
		fall  = (g10 <= HW'(ONE_I)) && (last5 > HW'(ONE_I));

		sus_x = XW'(sustain_q);
		s_eff = (sus_x > XW'(ONE_I - 1)) ? FB'(ONE_I - 1) : FB'(sustain_q);

		eu_t = t_q - up_tick_q;
		ed_t = t_q - down_tick_q;
		eu_x = CW'(eu_t);
		ed_x = CW'(ed_t);
		a_x  = CW'(attack_q);
		ad_x = CW'(attack_q) + CW'(decay_q);
		r_x  = CW'(release_q);
		t_x  = CW'(t_q);

		direct_post = (stage_q == STG_SUSTAIN) || second_q;
		div_start   = (state_q == S_POST) && !direct_post;
		f_w         = (MB+1)'(ONE_I) - (MB+1)'(div_quo);
		lvl_sat     = (lvl_q > LW'(ONE_I - 1)) ? LW'(ONE_I - 1) : lvl_q;
	end

	adsr_div #(
		.QW (MA),
		.MB (MB)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (prod_q),
		.den    (divisor_q),
		.done   (div_done),
		.quo    (div_quo)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attack_q  <= '0;
			decay_q   <= '0;
			sustain_q <= '0;
			release_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_ATTACK:  attack_q  <= cfg_data;
				CFG_DECAY:   decay_q   <= cfg_data;
				CFG_SUSTAIN: sustain_q <= cfg_data[LEVEL_W-1:0];
				CFG_RELEASE: release_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			stage_q        <= STG_NONE;
			second_q       <= 1'b0;
			last_gate_q    <= '0;
			up_tick_q      <= '0;
			down_tick_q    <= '0;
			result_valid_q <= 1'b0;
			result_q       <= '0;
		end else begin
			if ((state_q == S_DONE) && out_free) begin
				result_valid_q <= 1'b1;
			end else if (result_valid_q && !result_stall) begin
				result_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (rise) begin
							up_tick_q <= t_in;
						end else if (fall) begin
							down_tick_q <= t_in;
						end
						last_gate_q <= sample.gate_level;
						second_q    <= 1'b0;
						state_q     <= S_SEL;
					end
				end
				S_SEL: begin
					state_q <= S_MUL;
					if (g_q != '0) begin
						if (eu_x < a_x) begin
							stage_q <= STG_ATTACK;
						end else if (eu_x < ad_x) begin
							stage_q <= STG_DECAY;
						end else begin
							stage_q <= STG_SUSTAIN;
						end
					end else if ((ed_x < r_x) && (t_x > r_x)) begin
						stage_q <= STG_RELEASE;
					end else begin
						stage_q <= STG_NONE;
						state_q <= S_DONE;
					end
				end
				S_MUL: begin
					state_q <= S_POST;
				end
				S_POST: begin
					state_q <= direct_post ? S_DONE : S_DIV;
				end
				S_DIV: begin
					if (div_done) begin
						if (stage_q == STG_DECAY) begin
							second_q <= 1'b1;
							state_q  <= S_MUL;
						end else begin
							state_q <= S_DONE;
						end
					end
				end
				S_DONE: begin
					if (out_free) begin
						result_q.level <= lvl_sat[LEVEL_W-1:0];
						result_q.stage <= stage_q;
						state_q        <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					t_q <= t_in;
					g_q <= sample.gate_level;
				end
			end
			S_SEL: begin
				lvl_q <= '0;
				if (g_q != '0) begin
					if (eu_x < a_x) begin
						op_a_q    <= MA'(g_q);
						op_b_q    <= MB'(eu_x);
						divisor_q <= attack_q;
					end else if (eu_x < ad_x) begin
						op_a_q    <= MA'(ONE_I) - MA'(s_eff);
						op_b_q    <= MB'(eu_x - a_x);
						divisor_q <= decay_q;
					end else begin
						op_a_q <= MA'(g_q);
						op_b_q <= MB'(s_eff);
					end
				end else begin
					op_a_q    <= MA'(s_eff);
					op_b_q    <= MB'(ed_x);
					divisor_q <= release_q;
				end
			end
			S_MUL: begin
				prod_q <= PW'(op_a_q) * PW'(op_b_q);
			end
			S_POST: begin
				if (direct_post) begin
					lvl_q <= LW'(prod_q >> FB);
				end
			end
			S_DIV: begin
				if (div_done) begin
					if (stage_q == STG_DECAY) begin
						op_a_q <= MA'(g_q);
						op_b_q <= MB'(f_w);
					end else if (stage_q == STG_RELEASE) begin
						lvl_q <= LW'(s_eff) - LW'(div_quo);
					end else begin
						lvl_q <= LW'(div_quo);
					end
				end
			end
			default: ;
		endcase
	end

	a_accept_idle: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == S_SEL)
		else $error("request accepted outside idle");

	a_div_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == S_DIV)
		else $error("divider done outside divide step");

	a_stage_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> result.stage <= STG_RELEASE)
		else $error("result stage code out of range");

	a_release_cap: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.stage == STG_RELEASE) |-> result.level <= sustain_q)
		else $error("release level above sustain");

endmodule

// ===== design/adsr_div.sv =====
// ----------------------------------------------------------------------------
// adsr_div
// Radix-2 restoring divider, one quotient bit per cycle. The caller
// guarantees the quotient fits in QW bits, so only QW steps are run.
// ----------------------------------------------------------------------------
module adsr_div #(
	parameter int unsigned QW = 17,
	parameter int unsigned MB = 24
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic [QW+MB-1:0]         num,
	input  logic [adsr_pkg::DUR_W-1:0] den,
	output logic                     done,
	output logic [QW-1:0]            quo
);
	import adsr_pkg::*;

	localparam int unsigned PW   = QW + MB;
	localparam int unsigned CNTW = $clog2(QW);

	logic            busy_q;
	logic            done_q;
	logic [CNTW-1:0] cnt_q;
	logic [MB:0]     rem_q;
	logic [QW-1:0]   quo_q;
	logic [MB:0]     den_q;
	logic [MB:0]     rem_sh;
	logic            qbit;

	always_comb begin
		rem_sh = {rem_q[MB-1:0], quo_q[QW-1]};
		qbit   = (rem_sh >= den_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNTW'(QW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= {1'b0, num[PW-1:QW]};
			quo_q <= num[QW-1:0];
			den_q <= (MB+1)'(den);
		end else if (busy_q) begin
			rem_q <= qbit ? (rem_sh - den_q) : rem_sh;
			quo_q <= {quo_q[QW-2:0], qbit};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule

// ===== tb/adsr_env_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// adsr_env_checker
// Watches the configuration, sample and result channels of the ADSR envelope
// core. Keeps its own copy of the registers and the gate state, predicts the
// level and stage of every accepted request, and compares each accepted result
// with the oldest prediction. Reports mismatches and hands counts to the top.
// ----------------------------------------------------------------------------
module adsr_env_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           sample_valid,
	input  logic                           sample_stall,
	input  adsr_pkg::adsr_in_t             sample,
	input  logic                           result_valid,
	input  logic                           result_stall,
	input  adsr_pkg::adsr_out_t            result,
	input  logic                           cfg_valid,
	input  logic                           cfg_ready,
	input  logic [adsr_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [adsr_pkg::CFG_DAT_W-1:0] cfg_data,
	output int                             errors,
	output int                             pending,
	output int                             checked,
	output logic [4:0]                     stages_seen
);
	import adsr_pkg::*;

	localparam int          FRAC = 16;
	localparam logic [63:0] ONE  = 64'd1 << FRAC;

	logic [DUR_W-1:0]   attack_len, decay_len, release_len;
	logic [LEVEL_W-1:0] sustain_q;
	logic [GATE_W-1:0]  gate_prev;
	logic [TIN_W-1:0]   up_tick, down_tick;
	adsr_out_t          env_due[$];
	adsr_out_t          want;
	int                 n_err, n_chk;
	logic [4:0]         seen;

	function automatic adsr_out_t envelope_step(input adsr_in_t req);
		logic [63:0] g, s, lvl, f;
		logic [31:0] eu, ed;
		adsr_out_t   o;
		g = 64'(req.gate_level);
		s = 64'(sustain_q);
		// hysteresis: up above 0.1 from at most 0.2, down to at most 0.1 from above 0.2
		if (g * 10 > ONE && 64'(gate_prev) * 5 <= ONE)
			up_tick = req.time_now;
		else if (g * 10 <= ONE && 64'(gate_prev) * 5 > ONE)
			down_tick = req.time_now;
		gate_prev = req.gate_level;
		eu = req.time_now - up_tick;
		ed = req.time_now - down_tick;
		lvl = '0;
		o.stage = STG_NONE;
		if (g != 0) begin
			if (64'(eu) < 64'(attack_len)) begin
				o.stage = STG_ATTACK;
				lvl = (g * 64'(eu)) / 64'(attack_len);
			end else if (64'(eu) < 64'(attack_len) + 64'(decay_len)) begin
				o.stage = STG_DECAY;
				f = ONE - ((ONE - s) * (64'(eu) - 64'(attack_len))) / 64'(decay_len);
				lvl = (g * f) >> FRAC;
			end else begin
				o.stage = STG_SUSTAIN;
				lvl = (g * s) >> FRAC;
			end
		end else if (64'(ed) < 64'(release_len) && 64'(req.time_now) > 64'(release_len)) begin
			o.stage = STG_RELEASE;
			lvl = s - (s * 64'(ed)) / 64'(release_len);
		end
		if (lvl > ONE - 1)
			lvl = ONE - 1;
		o.level = lvl[LEVEL_W-1:0];
		return o;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attack_len = '0;
			decay_len = '0;
			sustain_q = '0;
			release_len = '0;
			gate_prev = '0;
			up_tick = '0;
			down_tick = '0;
			env_due.delete();
			n_err = 0;
			n_chk = 0;
			seen = '0;
			errors <= 0;
			pending <= 0;
			checked <= 0;
			stages_seen <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_ATTACK:  attack_len = cfg_data;
					CFG_DECAY:   decay_len = cfg_data;
					CFG_SUSTAIN: sustain_q = cfg_data[LEVEL_W-1:0];
					CFG_RELEASE: release_len = cfg_data;
					default: ;
				endcase
			end
			if (sample_valid && !sample_stall)
				env_due.push_back(envelope_step(sample));
			if (result_valid && !result_stall) begin
				if (env_due.size() == 0) begin
					if (n_err < 10)
						$display("%0t: result level %0d stage %0d with no request waiting",
							$realtime, result.level, result.stage);
					n_err++;
				end else begin
					want = env_due.pop_front();
					n_chk++;
					if (result.stage < 5)
						seen[result.stage] = 1'b1;
					if (result.level !== want.level || result.stage !== want.stage) begin
						if (n_err < 10)
							$display({"%0t: mismatch: expected level %0d stage %0d,",
								" got level %0d stage %0d"},
								$realtime, want.level, want.stage,
								result.level, result.stage);
						n_err++;
					end
				end
			end
			errors <= n_err;
			pending <= env_due.size();
			checked <= n_chk;
			stages_seen <= seen;
		end
	end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Stimulus for the ADSR envelope core: a directed run through every stage,
// the gate hysteresis thresholds, time wrap and the release guard, then random
// notes under random register settings, with request gaps and result stalls.
// Checking is done by adsr_env_checker; this module gives the verdict.
// ----------------------------------------------------------------------------
module testbench;
	import adsr_pkg::*;

	localparam int          ITEMS       = 950;
	localparam int          HOLD_CYCLES = 400;
	localparam int          LIMIT       = 1_000_000;
	localparam logic [15:0] G_ON_MIN    = 16'd6554;
	localparam logic [15:0] G_OFF_MAX   = 16'd6553;
	localparam logic [15:0] G_HI_EDGE   = 16'd13107;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 sample_valid = 1'b0;
	logic                 sample_stall;
	adsr_in_t             sample = '0;
	logic                 result_valid;
	logic                 result_stall = 1'b0;
	adsr_out_t            result;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = CFG_ATTACK;
	logic [CFG_DAT_W-1:0] cfg_data = '0;

	int          errors, pending, checked;
	logic [4:0]  stages_seen;
	int          n_sent = 0, n_settings = 0, hold_req = 0, hold_ack = 0, cycles = 0;
	logic        calm = 1'b0;
	logic [23:0] a_len = '0, d_len = '0, r_len = '0;
	logic [31:0] now = '0;

	adsr_envelope_generator_core dut (.*);
	adsr_env_checker chk (.*);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	function automatic int gap_len();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [23:0] pick_len();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 10)
			return '0;
		if (r < 17)
			return 24'hFFFFFF;
		if (r < 25)
			return 24'd1;
		if (r < 85)
			return 24'($urandom_range(2, 64));
		return 24'($urandom_range(65, 24'hFFFFFE));
	endfunction

	function automatic logic [15:0] pick_sustain();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 15)
			return '0;
		if (r < 30)
			return 16'hFFFF;
		return 16'($urandom_range(1, 16'hFFFE));
	endfunction

	function automatic logic [31:0] step_for(input logic [31:0] span);
		if ($urandom_range(0, 3) == 0)
			return $urandom_range(0, span + span / 2 + 2);
		return $urandom_range(0, span / 3 + 1);
	endfunction

	// result side: random stall runs, plus long hold-offs on request
	initial begin : result_side
		int stall_run, hold_left;
		stall_run = 0;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (hold_left == 0 && hold_ack != hold_req) begin
				hold_ack = hold_req;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				result_stall <= 1'b1;
			end else if (stall_run > 0) begin
				stall_run--;
				result_stall <= 1'b1;
			end else begin
				result_stall <= 1'b0;
				if (!calm && $urandom_range(0, 2) == 0)
					stall_run = gap_len();
			end
		end
	end

	task automatic send(input logic [31:0] t, input logic [15:0] g);
		int gap;
		sample_valid <= 1'b1;
		sample <= '{time_now: t, gate_level: g};
		do @(posedge clk); while (sample_stall);
		n_sent++;
		if (!calm) begin
			gap = gap_len();
			if (gap > 0) begin
				sample_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	task automatic drain();
		sample_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic set_envelope(input logic [23:0] a, input logic [23:0] d,
			input logic [15:0] s, input logic [23:0] r);
		cfg_write(CFG_ATTACK, a);
		cfg_write(CFG_DECAY, d);
		cfg_write(CFG_SUSTAIN, {8'd0, s});
		cfg_write(CFG_RELEASE, r);
		cfg_valid <= 1'b0;
		a_len = a;
		d_len = d;
		r_len = r;
		n_settings++;
	endtask

	task automatic play_note();
		logic [15:0] g_on, g_off;
		case ($urandom_range(0, 4))
			0: g_on = G_ON_MIN;
			1: g_on = 16'hFFFF;
			2: g_on = 16'($urandom_range(G_ON_MIN, G_HI_EDGE));
			default: g_on = 16'($urandom_range(G_ON_MIN, 16'hFFFF));
		endcase
		case ($urandom_range(0, 9))
			0, 1: g_off = 16'($urandom_range(1, G_OFF_MAX));
			2: g_off = 16'($urandom_range(G_ON_MIN, G_HI_EDGE));
			default: g_off = '0;
		endcase
		send(now, g_on);
		repeat ($urandom_range(2, 7)) begin
			now = now + step_for(32'(a_len) + 32'(d_len));
			if ($urandom_range(0, 3) == 0)
				g_on = 16'($urandom_range(G_ON_MIN, 16'hFFFF));
			send(now, g_on);
		end
		now = now + step_for(32'(r_len));
		send(now, g_off);
		repeat ($urandom_range(1, 4)) begin
			now = now + step_for(32'(r_len));
			send(now, ($urandom_range(0, 3) == 0) ? g_off : 16'd0);
		end
	endtask

	initial begin
		int phase;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// registers at reset: zero durations, zero sustain
		send(32'd0, 16'd0);
		send(32'd5, 16'hFFFF);
		drain();
		set_envelope(24'd10, 24'd10, 16'h8000, 24'd10);
		send(32'd100, 16'hFFFF);
		send(32'd105, 16'hFFFF);
		send(32'd112, 16'hFFFF);
		send(32'd125, 16'hFFFF);
		send(32'd130, 16'd0);
		send(32'd135, 16'd0);
		send(32'd145, 16'd0);
		// hysteresis edges
		send(32'd150, G_ON_MIN);
		send(32'd152, G_HI_EDGE);
		send(32'd155, G_OFF_MAX);
		send(32'd160, G_HI_EDGE + 16'd1);
		send(32'd165, G_OFF_MAX);
		send(32'd170, 16'd0);
		// time going backward, wrap, release guard
		send(32'd3, 16'd0);
		send(32'hFFFF_FFF0, 16'hFFFF);
		send(32'd0, 16'hFFFF);
		send(32'd2, 16'd0);
		drain();
		set_envelope(24'hFFFFFF, 24'hFFFFFF, 16'hFFFF, 24'hFFFFFF);
		send(32'd1000, 16'hFFFF);
		send(32'd1000 + 32'hFF_FFFE, 16'hFFFF);
		send(32'd1000 + 32'h1FF_FFFD, 16'h8000);
		send(32'd1000 + 32'h1FF_FFFE, 16'hFFFF);
		send(32'h0300_0000, 16'd0);
		send(32'h0300_0000 + 32'hFF_FFFE, 16'd0);
		drain();
		set_envelope('0, '0, '0, '0);
		send(32'h10, 16'hFFFF);
		send(32'h20, 16'd0);

		phase = 0;
		while (n_sent < ITEMS) begin
			drain();
			calm = 1'b0;
			set_envelope(pick_len(), pick_len(), pick_sustain(), pick_len());
			case ($urandom_range(0, 4))
				0: now = 32'hFFFF_FFFF - $urandom_range(0, 300);
				1: now = $urandom_range(0, 300);
				default: now = $urandom;
			endcase
			if (phase == 1 || $urandom_range(0, 19) == 0) begin
				calm = 1'b1;
				hold_req++;
			end else begin
				calm = ($urandom_range(0, 3) == 0);
			end
			repeat ($urandom_range(2, 5)) begin
				if ($urandom_range(0, 6) == 0)
					send($urandom, 16'($urandom));
				else
					play_note();
			end
			phase++;
		end

		drain();
		repeat (30) @(posedge clk);
		$display("sent %0d requests over %0d register settings, %0d results checked",
			n_sent, n_settings, checked);
		$display("stages reached (release..none) %05b, receiver hold-offs %0d",
			stages_seen, hold_req);
		if (errors == 0 && pending == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

// ===== adsr_envelope_generator_core.f =====
design/adsr_pkg.sv
design/adsr_div.sv
design/adsr_envelope_generator_core.sv
tb/adsr_env_checker.sv
tb/testbench.sv
